// ----- rtl/core/luvak_pkg.sv -----
// Shared widths, latencies, result type and register indexes for the Luv alpha key block.
package luvak_pkg;

	localparam int CBRT_STEPS = 15;
	localparam int L_W        = 19;
	localparam int UV_QW      = 25;
	localparam int UV_W       = UV_QW + 1;
	localparam int LUV_LAT    = 1 + CBRT_STEPS + 2 + UV_QW + 1;

	localparam logic CFG_BACKGROUND = 1'b0;
	localparam logic CFG_FONT       = 1'b1;

	localparam logic [23:0] BACKGROUND_RST = 24'hFFFFFF;
	localparam logic [23:0] FONT_RST       = 24'h000000;

	typedef struct packed {
		logic [L_W-1:0]         l;
		logic signed [UV_W-1:0] u;
		logic signed [UV_W-1:0] v;
	} luv_t;

endpackage

// ----- rtl/core/luvak_dly.sv -----
// Fixed-length delay line for payload alignment.
module luvak_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] pipe_q [N];

	always_ff @(posedge clk) begin
		pipe_q[0] <= d;
		for (int i = 1; i < N; i++) begin
			pipe_q[i] <= pipe_q[i-1];
		end
	end

	assign q = pipe_q[N-1];

endmodule

// ----- rtl/core/luvak_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, truncating signed result.
module luvak_div #(
	parameter int DW = 33,
	parameter int QW = 25,
	parameter int NW = 55
) (
	input  logic                clk,
	input  logic [NW-1:0]       num,
	input  logic [DW-1:0]       den,
	input  logic                neg,
	output logic signed [QW:0]  quo
);

	localparam int RW = DW + QW;

	logic [RW-1:0] rem_w [QW+1];
	logic [DW-1:0] den_w [QW+1];
	logic [QW-1:0] q_w   [QW+1];
	logic          neg_w [QW+1];

	assign rem_w[0] = RW'(num);
	assign den_w[0] = den;
	assign q_w[0]   = '0;
	assign neg_w[0] = neg;

	for (genvar g = 0; g < QW; g++) begin : g_stage
		localparam int B = QW - 1 - g;
		logic [RW-1:0] dsh;
		logic          ge;
		logic [RW-1:0] rem_s;
		logic [DW-1:0] den_s;
		logic [QW-1:0] q_s;
		logic          neg_s;

		always_comb begin
			dsh = RW'(den_w[g]) << B;
			ge  = rem_w[g] >= dsh;
		end

		always_ff @(posedge clk) begin
			rem_s <= ge ? rem_w[g] - dsh : rem_w[g];
			q_s   <= ge ? (q_w[g] | (QW'(1) << B)) : q_w[g];
			den_s <= den_w[g];
			neg_s <= neg_w[g];
		end

		assign rem_w[g+1] = rem_s;
		assign den_w[g+1] = den_s;
		assign q_w[g+1]   = q_s;
		assign neg_w[g+1] = neg_s;
	end

	always_ff @(posedge clk) begin
		quo <= neg_w[QW] ? -$signed({1'b0, q_w[QW]}) : $signed({1'b0, q_w[QW]});
	end

endmodule

// ----- rtl/core/luvak_luv.sv -----
// RGB to CIE Luv converter, fixed latency, one pixel per cycle.
module luvak_luv (
	input  logic               clk,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	output luvak_pkg::luv_t    luv
);

	localparam int T_W  = luvak_pkg::CBRT_STEPS;
	localparam int YY_W = 42;
	localparam int DL   = luvak_pkg::CBRT_STEPS - 2;
	localparam logic [63:0] YDIV = 64'd255 * 64'd1000356;
	localparam logic [43:0] KY_R = 44'((64'd212671 << 42) / YDIV);
	localparam logic [43:0] KY_G = 44'((64'd715160 << 42) / YDIV);
	localparam logic [43:0] KY_B = 44'((64'd72169 << 42) / YDIV);
	localparam logic [YY_W-1:0] Y_KNEE = YY_W'((64'd856 << 42) / 64'd100000);

	// stage 1: tristimulus sums
	logic [28:0]      sx_s1, sy_s1, sz_s1;
	logic [YY_W-1:0]  yy_s1;

	always_ff @(posedge clk) begin
		sx_s1 <= 29'(29'(red) * 29'd412454 + 29'(green) * 29'd357580 + 29'(blue) * 29'd180423);
		sy_s1 <= 29'(29'(red) * 29'd212671 + 29'(green) * 29'd715160 + 29'(blue) * 29'd72169);
		sz_s1 <= 29'(29'(red) * 29'd19334 + 29'(green) * 29'd119193 + 29'(blue) * 29'd950227);
		yy_s1 <= YY_W'(44'(red) * KY_R + 44'(green) * KY_G + 44'(blue) * KY_B);
	end

	// stages 2..3: denominator, chroma numerators, linear segment
	logic [32:0]        den_s2, den_s3;
	logic [28:0]        sx_s2, sy_s2;
	logic [25:0]        lina_s2;
	logic               knee_s2, knee_s3;
	logic signed [36:0] nu_s3, nv_s3;
	logic [18:0]        lin_s3;

	always_ff @(posedge clk) begin
		den_s2  <= 33'(sx_s1) + 33'(sy_s1) * 33'd15 + 33'(sz_s1) * 33'd3;
		lina_s2 <= 26'((56'(yy_s1) * 56'd9033) >> 30);
		knee_s2 <= yy_s1 > Y_KNEE;
		sx_s2   <= sx_s1;
		sy_s2   <= sy_s1;
		nu_s3   <= $signed(37'(37'(sx_s2) * 37'd52)) - $signed(37'(37'(den_s2) << 2));
		nv_s3   <= $signed(37'(37'(sy_s2) * 37'd117)) - $signed(37'(37'(den_s2) * 37'd9));
		lin_s3  <= 19'((58'(lina_s2) * 58'h0CCCCCCCD) >> 35);
		den_s3  <= (den_s2 == '0) ? 33'd1 : den_s2;
		knee_s3 <= knee_s2;
	end

	logic [36:0] nu_d, nv_d;
	logic [18:0] lin_d;
	logic [32:0] den_d;
	logic        knee_d;

	luvak_dly #(.W(37 + 37 + 19 + 33 + 1), .N(DL)) u_align (
		.clk (clk),
		.d   ({nu_s3, nv_s3, lin_s3, den_s3, knee_s3}),
		.q   ({nu_d, nv_d, lin_d, den_d, knee_d})
	);

	// cube root, one bit per stage with running square and cube
	logic [YY_W-1:0] yy_w [T_W+1];
	logic [T_W-1:0]  t_w  [T_W+1];
	logic [29:0]     t2_w [T_W+1];
	logic [44:0]     t3_w [T_W+1];

	assign yy_w[0] = yy_s1;
	assign t_w[0]  = '0;
	assign t2_w[0] = '0;
	assign t3_w[0] = '0;

	for (genvar g = 0; g < T_W; g++) begin : g_cbrt
		localparam int K = T_W - 1 - g;
		logic [46:0]     a, bb, c3;
		logic [30:0]     c2;
		logic            ok;
		logic [YY_W-1:0] yy_s;
		logic [T_W-1:0]  t_s;
		logic [29:0]     t2_s;
		logic [44:0]     t3_s;

		always_comb begin
			a  = 47'(t2_w[g]) << K;
			bb = 47'(t_w[g]) << (2 * K);
			c3 = 47'(t3_w[g]) + a + (a << 1) + bb + (bb << 1) + (47'(1) << (3 * K));
			c2 = 31'(t2_w[g]) + (31'(t_w[g]) << (K + 1)) + (31'(1) << (2 * K));
			ok = c3 <= 47'(yy_w[g]);
		end

		always_ff @(posedge clk) begin
			yy_s <= yy_w[g];
			t_s  <= ok ? (t_w[g] | (T_W'(1) << K)) : t_w[g];
			t2_s <= ok ? c2[29:0] : t2_w[g];
			t3_s <= ok ? c3[44:0] : t3_w[g];
		end

		assign yy_w[g+1] = yy_s;
		assign t_w[g+1]  = t_s;
		assign t2_w[g+1] = t2_s;
		assign t3_w[g+1] = t3_s;
	end

	// lightness, then products for the chroma division
	logic [18:0]        l_s17;
	logic [35:0]        au_s17, av_s17;
	logic               ngu_s17, ngv_s17;
	logic [32:0]        den_s17, den_s18;
	logic [54:0]        pu_s18, pv_s18;
	logic               ngu_s18, ngv_s18;
	logic signed [36:0] nus, nvs;
	logic [19:0]        l29;

	always_comb begin
		nus = $signed(nu_d);
		nvs = $signed(nv_d);
		l29 = 20'(t_w[T_W]) * 20'd29 - 20'd65536;
	end

	always_ff @(posedge clk) begin
		l_s17   <= knee_d ? l29[18:0] : lin_d;
		au_s17  <= nus[36] ? 36'(-nus) : nus[35:0];
		av_s17  <= nvs[36] ? 36'(-nvs) : nvs[35:0];
		ngu_s17 <= nus[36];
		ngv_s17 <= nvs[36];
		den_s17 <= den_d;
		pu_s18  <= 55'(l_s17) * 55'(au_s17);
		pv_s18  <= 55'(l_s17) * 55'(av_s17);
		ngu_s18 <= ngu_s17;
		ngv_s18 <= ngv_s17;
		den_s18 <= den_s17;
	end

	luvak_div #(.DW(33), .QW(luvak_pkg::UV_QW), .NW(55)) u_div_u (
		.clk (clk),
		.num (pu_s18),
		.den (den_s18),
		.neg (ngu_s18),
		.quo (luv.u)
	);

	luvak_div #(.DW(33), .QW(luvak_pkg::UV_QW), .NW(55)) u_div_v (
		.clk (clk),
		.num (pv_s18),
		.den (den_s18),
		.neg (ngv_s18),
		.quo (luv.v)
	);

	luvak_dly #(.W(luvak_pkg::L_W), .N(luvak_pkg::UV_QW + 2)) u_l_dly (
		.clk (clk),
		.d   (l_s17),
		.q   (luv.l)
	);

endmodule

// ----- rtl/core/luv_distance_alpha_key_top.sv -----
// Top level: Luv distance alpha key, pixel in, alpha byte out.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+------------------------------
//  pixel    | red, green, blue               | start high, busy low
//  alpha    | alpha                          | done strobe, one cycle
//  config   | cfg_we, cfg_idx, cfg_wdata     | cfg_we high at the edge
//
// One pixel enters every cycle; each beat gives its alpha after the cube root
// stages and the two bit-per-stage dividers in its path.
// busy is never raised. Reset clears the valid bits and loads the reference
// colours; the datapath registers are not reset. The receiver cannot stall.
module luv_distance_alpha_key_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [23:0] cfg_wdata,
	output logic        done,
	output logic [7:0]  alpha
);

	localparam int POST  = 18;
	localparam int TOTAL = luvak_pkg::LUV_LAT + POST;
	localparam logic [53:0] C2_MIN = 54'd17;

	logic [23:0] bg_q, fn_q;
	logic [TOTAL-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q <= luvak_pkg::BACKGROUND_RST;
			fn_q <= luvak_pkg::FONT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				luvak_pkg::CFG_BACKGROUND: bg_q <= cfg_wdata;
				luvak_pkg::CFG_FONT:       fn_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[TOTAL-2:0], start & ~busy};
		end
	end

	luvak_pkg::luv_t px, bk, fn;

	luvak_luv u_px (.clk(clk), .red(red), .green(green), .blue(blue), .luv(px));
	luvak_luv u_bk (.clk(clk), .red(bg_q[23:16]), .green(bg_q[15:8]), .blue(bg_q[7:0]),
		.luv(bk));
	luvak_luv u_fn (.clk(clk), .red(fn_q[23:16]), .green(fn_q[15:8]), .blue(fn_q[7:0]),
		.luv(fn));

	// differences
	logic signed [19:0] fl_s1, bl_s1, cl_s1;
	logic signed [26:0] fu_s1, fv_s1, bu_s1, bv_s1, cu_s1, cv_s1;

	always_ff @(posedge clk) begin
		fl_s1 <= $signed({1'b0, fn.l}) - $signed({1'b0, px.l});
		bl_s1 <= $signed({1'b0, bk.l}) - $signed({1'b0, px.l});
		cl_s1 <= $signed({1'b0, bk.l}) - $signed({1'b0, fn.l});
		fu_s1 <= 27'(fn.u) - 27'(px.u);
		fv_s1 <= 27'(fn.v) - 27'(px.v);
		bu_s1 <= 27'(bk.u) - 27'(px.u);
		bv_s1 <= 27'(bk.v) - 27'(px.v);
		cu_s1 <= 27'(bk.u) - 27'(fn.u);
		cv_s1 <= 27'(bk.v) - 27'(fn.v);
	end

	// squares
	logic signed [53:0] fl2_s2, fu2_s2, fv2_s2, bl2_s2, bu2_s2, bv2_s2;
	logic signed [53:0] cl2_s2, cu2_s2, cv2_s2;

	always_ff @(posedge clk) begin
		fl2_s2 <= fl_s1 * fl_s1;
		fu2_s2 <= fu_s1 * fu_s1;
		fv2_s2 <= fv_s1 * fv_s1;
		bl2_s2 <= bl_s1 * bl_s1;
		bu2_s2 <= bu_s1 * bu_s1;
		bv2_s2 <= bv_s1 * bv_s1;
		cl2_s2 <= cl_s1 * cl_s1;
		cu2_s2 <= cu_s1 * cu_s1;
		cv2_s2 <= cv_s1 * cv_s1;
	end

	// squared distances
	logic [53:0] dfq_s3, dbq_s3, c2_s3;

	always_ff @(posedge clk) begin
		dfq_s3 <= 54'(fl2_s2) + 54'(fu2_s2) + 54'(fv2_s2);
		dbq_s3 <= 54'(bl2_s2) + 54'(bu2_s2) + 54'(bv2_s2);
		c2_s3  <= 54'(cl2_s2) + 54'(cu2_s2) + 54'(cv2_s2);
	end

	// numerator and denominator of D
	logic [53:0]        c2_s4;
	logic signed [55:0] nd_s4, num_s5;
	logic [54:0]        den2_s5, den2_s6, den2_s7;
	logic [54:0]        mag_s6;
	logic [62:0]        p_s7, dsh_s7, p_s8;
	logic [54:0]        den2_s8;
	logic               sat_s8;

	always_ff @(posedge clk) begin
		c2_s4   <= (c2_s3 < C2_MIN) ? C2_MIN : c2_s3;
		nd_s4   <= $signed({2'b00, dfq_s3}) - $signed({2'b00, dbq_s3});
		num_s5  <= nd_s4 + $signed({2'b00, c2_s4});
		den2_s5 <= {c2_s4, 1'b0};
		mag_s6  <= num_s5[55] ? 55'(-num_s5) : num_s5[54:0];
		den2_s6 <= den2_s5;
		p_s7    <= (63'(mag_s6) << 8) - 63'(mag_s6);
		dsh_s7  <= 63'(den2_s6) << 8;
		den2_s7 <= den2_s6;
		sat_s8  <= p_s7 >= dsh_s7;
		p_s8    <= (p_s7 >= dsh_s7) ? '0 : p_s7;
		den2_s8 <= den2_s7;
	end

	logic signed [8:0] q;
	logic              sat_d;

	luvak_div #(.DW(55), .QW(8), .NW(63)) u_div_a (
		.clk (clk),
		.num (p_s8),
		.den (den2_s8),
		.neg (1'b0),
		.quo (q)
	);

	luvak_dly #(.W(1), .N(9)) u_sat_dly (
		.clk (clk),
		.d   (sat_s8),
		.q   (sat_d)
	);

	logic [7:0] alpha_q;

	always_ff @(posedge clk) begin
		alpha_q <= sat_d ? 8'd0 : 8'd255 - q[7:0];
	end

	assign alpha = alpha_q;
	assign done  = vld_q[TOTAL-1];

`ifndef ASSERT_OFF
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##TOTAL done)
		else $error("accepted beat gave no alpha");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, TOTAL))
		else $error("alpha strobe without accepted beat");
`endif

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the Luv distance alpha key block.
module testbench;

	localparam longint unsigned YDIV   = 64'd255 * 64'd1000356;
	localparam longint unsigned KY_R   = (64'd212671 << 42) / YDIV;
	localparam longint unsigned KY_G   = (64'd715160 << 42) / YDIV;
	localparam longint unsigned KY_B   = (64'd72169 << 42) / YDIV;
	localparam longint unsigned Y_KNEE = (64'd856 << 42) / 64'd100000;
	localparam longint unsigned C2_MIN = 64'd17;
	localparam int DRAIN_CYCLES = 70;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int N_RANDOM     = 800;

	typedef struct {
		logic [23:0] bg;
		logic [23:0] fg;
		logic [7:0]  r, g, b;
		int          alpha;	// -1: take from predictor
	} vec_t;

	logic        clk, arst_n, start, cfg_we, cfg_idx;
	logic [7:0]  red, green, blue;
	logic [23:0] cfg_wdata;
	logic        busy, done;
	logic [7:0]  alpha;

	logic [23:0] bg_ref, fg_ref;
	logic [7:0]  alpha_q[$];
	int          pending_alpha[$];
	int          errors, cycles, idle_pct;

	luv_distance_alpha_key_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.red(red), .green(green), .blue(blue),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.done(done), .alpha(alpha)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned cbrt_q14(input longint unsigned n);
		longint unsigned t, c;
		t = 0;
		for (int i = 14; i >= 0; i--) begin
			c = t | (64'd1 << i);
			if (c * c * c <= n)
				t = c;
		end
		return t;
	endfunction

	function automatic void rgb_to_luv(input logic [7:0] r, g, b, output longint l, u, v);
		longint unsigned sx, sy, sz, yy, den;
		longint d;
		sx = 64'd412454 * r + 64'd357580 * g + 64'd180423 * b;
		sy = 64'd212671 * r + 64'd715160 * g + 64'd72169 * b;
		sz = 64'd19334 * r + 64'd119193 * g + 64'd950227 * b;
		yy = KY_R * r + KY_G * g + KY_B * b;
		den = sx + 64'd15 * sy + 64'd3 * sz;
		if (yy > Y_KNEE)
			l = 29 * longint'(cbrt_q14(yy)) - 65536;
		else
			l = longint'((yy * 64'd9033) / (64'd10 << 30));
		if (den == 0) begin
			u = 0;
			v = 0;
		end else begin
			d = longint'(den);
			u = l * (longint'(64'd52 * sx) - 4 * d) / d;
			v = l * (longint'(64'd117 * sy) - 9 * d) / d;
		end
	endfunction

	function automatic longint unsigned sq_dist(input longint al, au, av, bl, bu, bv);
		return longint'(unsigned'((al - bl) * (al - bl))) + (au - bu) * (au - bu)
			+ (av - bv) * (av - bv);
	endfunction

	function automatic logic [7:0] predict_alpha(input logic [23:0] bg, fg,
			input logic [7:0] r, g, b);
		longint bl, bu, bv, fl, fu, fv, pl, pu, pv, num;
		longint unsigned c2, dfq, dbq, mag, t;
		rgb_to_luv(bg[23:16], bg[15:8], bg[7:0], bl, bu, bv);
		rgb_to_luv(fg[23:16], fg[15:8], fg[7:0], fl, fu, fv);
		rgb_to_luv(r, g, b, pl, pu, pv);
		c2 = sq_dist(bl, bu, bv, fl, fu, fv);
		if (c2 < C2_MIN)
			c2 = C2_MIN;
		dfq = sq_dist(fl, fu, fv, pl, pu, pv);
		dbq = sq_dist(bl, bu, bv, pl, pu, pv);
		num = longint'(dfq) + longint'(c2) - longint'(dbq);
		mag = num < 0 ? longint'(-num) : num;
		t = (mag * 64'd255) / (64'd2 * c2);
		if (t > 255)
			t = 255;
		return 8'(64'd255 - t);
	endfunction

	// accepted beat: queue its expected alpha
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			if (pending_alpha.size() != 0 && pending_alpha[0] >= 0)
				alpha_q.push_back(8'(pending_alpha[0]));
			else
				alpha_q.push_back(predict_alpha(bg_ref, fg_ref, red, green, blue));
			if (pending_alpha.size() != 0)
				void'(pending_alpha.pop_front());
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (alpha_q.size() == 0) begin
				$display("%0t: alpha expected none actual %0d", $time, alpha);
				errors++;
			end else begin
				if (alpha !== alpha_q[0]) begin
					$display("%0t: alpha expected %0d actual %0d", $time, alpha_q[0], alpha);
					errors++;
				end
				void'(alpha_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic push_pixel(input logic [7:0] r, g, b, input int exp_alpha);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		pending_alpha.push_back(exp_alpha);
		start <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		cfg_we <= 1'b0;
		while (alpha_q.size() != 0 || pending_alpha.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_refs(input logic [23:0] bg, fg);
		cfg_we <= 1'b1;
		cfg_idx <= luvak_pkg::CFG_BACKGROUND;
		cfg_wdata <= bg;
		@(posedge clk);
		bg_ref = bg;
		cfg_idx <= luvak_pkg::CFG_FONT;
		cfg_wdata <= fg;
		@(posedge clk);
		fg_ref = fg;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	vec_t directed[] = '{
		'{24'hFFFFFF, 24'h000000, 8'h00, 8'h00, 8'h00, 255},
		'{24'hFFFFFF, 24'h000000, 8'hFF, 8'hFF, 8'hFF, 0},
		'{24'hFFFFFF, 24'h000000, 8'hFF, 8'h00, 8'h00, -1},
		'{24'hFFFFFF, 24'h000000, 8'h00, 8'hFF, 8'h00, -1},
		'{24'hFFFFFF, 24'h000000, 8'h00, 8'h00, 8'hFF, -1},
		'{24'hFFFFFF, 24'h000000, 8'h01, 8'h01, 8'h01, -1},
		'{24'hFFFFFF, 24'h000000, 8'h80, 8'h80, 8'h80, -1},
		'{24'hFFFFFF, 24'h000000, 8'h55, 8'hAA, 8'h55, -1},
		'{24'h000000, 24'hFFFFFF, 8'h00, 8'h00, 8'h00, 0},
		'{24'h000000, 24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF, 255},
		'{24'h000000, 24'h000000, 8'h00, 8'h00, 8'h00, 128},
		'{24'h000000, 24'h000000, 8'hFF, 8'hFF, 8'hFF, 128},
		'{24'h123456, 24'h123456, 8'hAA, 8'h55, 8'hAA, 128},
		'{24'h808080, 24'h818181, 8'hFF, 8'h00, 8'h00, -1},
		'{24'h808080, 24'h818181, 8'h00, 8'h00, 8'hFF, -1},
		'{24'h0000FF, 24'hFF0000, 8'h00, 8'hFF, 8'h00, -1},
		'{24'h0000FF, 24'hFF0000, 8'h02, 8'h03, 8'h04, -1}
	};

	logic [23:0] phase_bg[4] = '{24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h0};
	logic [23:0] phase_fg[4] = '{24'hFFFFFF, 24'h000000, 24'h000000, 24'h0};
	int          phase_idle[4] = '{0, 55, 0, 12};

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		red = '0;
		green = '0;
		blue = '0;
		cfg_we = 1'b0;
		cfg_idx = luvak_pkg::CFG_BACKGROUND;
		cfg_wdata = '0;
		bg_ref = luvak_pkg::BACKGROUND_RST;
		fg_ref = luvak_pkg::FONT_RST;
		errors = 0;
		cycles = 0;
		idle_pct = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].bg != bg_ref || directed[i].fg != fg_ref) begin
				drain();
				set_refs(directed[i].bg, directed[i].fg);
			end
			push_pixel(directed[i].r, directed[i].g, directed[i].b, directed[i].alpha);
		end

		for (int p = 0; p < 8; p++) begin
			drain();
			if (p < 4 && p != 2)
				set_refs(phase_bg[p], phase_fg[p]);
			else
				set_refs(24'($urandom), 24'($urandom));
			idle_pct = phase_idle[p % 4];
			for (int i = 0; i < N_RANDOM / 8; i++)
				push_pixel(rand_chan(), rand_chan(), rand_chan(), -1);
		end
		drain();

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
